>>> rtl/agr_pkg.sv
package agr_pkg;

  localparam int NODE_W    = 7;
  localparam int NUM_NODES = 1 << NODE_W;
  localparam int GEN_W     = 7;
  localparam int STEP_W    = $clog2(NUM_NODES + 3);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_NODES + 2);
  localparam logic [GEN_W-1:0]  GEN_MAX   = '1;

  typedef enum logic [1:0] {
    REL_SAME    = 2'd0,
    REL_DIRECT  = 2'd1,
    REL_EQUAL   = 2'd2,
    REL_REMOVED = 2'd3
  } rel_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic q_start;
    logic step_eval;
    logic out_load;
  } agr_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } agr_stat_t;

endpackage

>>> rtl/agr_if.sv
interface agr_in_if;
  import agr_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, kind, node_a, node_b, input ready);
  modport sink   (input valid, kind, node_a, node_b, output ready);
endinterface

interface agr_out_if;
  import agr_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor;
  logic [GEN_W-1:0]  gen_a;
  logic [GEN_W-1:0]  gen_b;
  logic [1:0]        relation;
  logic              swapped;
  logic [GEN_W-1:0]  cousin_degree;
  logic [GEN_W-1:0]  removal;
  logic              no_common;

  modport source (output valid, ancestor, gen_a, gen_b, relation, swapped,
                  cousin_degree, removal, no_common, input ready);
  modport sink   (input valid, ancestor, gen_a, gen_b, relation, swapped,
                  cousin_degree, removal, no_common, output ready);
endinterface

>>> rtl/agr_ctrl.sv
module agr_ctrl
  import agr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_ready,
  output agr_cmd_t  cmd,
  input  agr_stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_QUERY) begin
            cmd.q_start = 1'b1;
            state_next  = S_READ;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      // memory read data lands at the end of this cycle
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.step_eval = 1'b1;
        state_next    = st.done ? S_RESULT : S_READ;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/agr_dp.sv
module agr_dp
  import agr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_data,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  agr_cmd_t          cmd,
  output agr_stat_t         st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_ancestor,
  output logic [GEN_W-1:0]  out_gen_a,
  output logic [GEN_W-1:0]  out_gen_b,
  output logic [1:0]        out_relation,
  output logic              out_swapped,
  output logic [GEN_W-1:0]  out_cousin_degree,
  output logic [GEN_W-1:0]  out_removal,
  output logic              out_no_common
);

  function automatic logic [GEN_W-1:0] sat_gen(input logic [STEP_W-1:0] g);
    logic [GEN_W-1:0] r;
    r = (g > STEP_W'(GEN_MAX)) ? GEN_MAX : g[GEN_W-1:0];
    return r;
  endfunction

  logic [NODE_W-1:0] parent_mem [NUM_NODES];
  logic [STEP_W-1:0] stamp_a_mem [NUM_NODES];
  logic [STEP_W-1:0] stamp_b_mem [NUM_NODES];

  logic [NODE_W-1:0] root;
  logic [NODE_W-1:0] cur_a, cur_b;
  logic              act_a, act_b;
  logic [STEP_W-1:0] step;
  logic [NUM_NODES-1:0] valid_a, valid_b;

  logic [NODE_W-1:0] par_a_rd, par_b_rd;
  logic [STEP_W-1:0] stamp_a_rd, stamp_b_rd;

  logic              res_met;
  logic [NODE_W-1:0] res_anc;
  logic [STEP_W-1:0] res_ga, res_gb;

  logic              done, met, stamp;
  logic [NODE_W-1:0] anc;
  logic [STEP_W-1:0] ga, gb;
  logic              vis_a, vis_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg_we) begin
      root <= cfg_data;
    end
  end

  // parent table: one write port, two read ports
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      parent_mem[in_node_a] <= in_node_b;
    end
    par_a_rd <= parent_mem[cur_a];
    par_b_rd <= parent_mem[cur_b];
  end

  // stamps of each climb, read at the other climb's position
  always_ff @(posedge clk) begin
    if (cmd.step_eval && stamp && act_a) begin
      stamp_a_mem[cur_a] <= step;
    end
    stamp_a_rd <= stamp_a_mem[cur_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.step_eval && stamp && act_b) begin
      stamp_b_mem[cur_b] <= step;
    end
    stamp_b_rd <= stamp_b_mem[cur_a];
  end

  assign vis_a = valid_a[cur_a] | valid_b[cur_a];
  assign vis_b = valid_a[cur_b] | valid_b[cur_b];

  always_comb begin
    done  = 1'b0;
    met   = 1'b0;
    stamp = 1'b0;
    anc   = cur_a;
    ga    = step - 1'b1;
    gb    = step - 1'b1;
    if (!act_a && !act_b) begin
      done = 1'b1;
    end else if (act_a && act_b && cur_a == cur_b && !vis_a) begin
      done = 1'b1;
      met  = 1'b1;
    end else if (act_a && vis_a) begin
      // met the other trail, or ran into its own cycle
      done = 1'b1;
      met  = valid_b[cur_a];
      gb   = stamp_b_rd - 1'b1;
    end else if (act_b && vis_b) begin
      done = 1'b1;
      met  = valid_a[cur_b];
      anc  = cur_b;
      ga   = stamp_a_rd - 1'b1;
    end else begin
      stamp = 1'b1;
      done  = (step == STEP_LAST);
    end
  end

  assign st.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_a   <= 1'b0;
      act_b   <= 1'b0;
      valid_a <= '0;
      valid_b <= '0;
      step    <= '0;
    end else if (cmd.q_start) begin
      act_a   <= 1'b1;
      act_b   <= 1'b1;
      valid_a <= '0;
      valid_b <= '0;
      step    <= STEP_W'(1);
    end else if (cmd.step_eval && stamp) begin
      step <= step + 1'b1;
      if (act_a) begin
        valid_a[cur_a] <= 1'b1;
        if (cur_a == root) act_a <= 1'b0;
      end
      if (act_b) begin
        valid_b[cur_b] <= 1'b1;
        if (cur_b == root) act_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      cur_a <= in_node_a;
      cur_b <= in_node_b;
    end else if (cmd.step_eval && stamp) begin
      if (act_a && cur_a != root) cur_a <= par_a_rd;
      if (act_b && cur_b != root) cur_b <= par_b_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_eval && done) begin
      res_met <= met;
      res_anc <= anc;
      res_ga  <= ga;
      res_gb  <= gb;
    end
  end

  // classification of the finished climb
  logic [STEP_W-1:0] lo, hi;
  logic [NODE_W-1:0] f_anc;
  logic [GEN_W-1:0]  f_ga, f_gb, f_deg, f_rem;
  rel_t              f_rel;
  logic              f_swap;

  assign lo = (res_ga < res_gb) ? res_ga : res_gb;
  assign hi = (res_ga < res_gb) ? res_gb : res_ga;

  always_comb begin
    f_anc  = '0;
    f_ga   = '0;
    f_gb   = '0;
    f_rel  = REL_SAME;
    f_swap = 1'b0;
    f_deg  = '0;
    f_rem  = '0;
    if (res_met) begin
      f_anc  = res_anc;
      f_ga   = sat_gen(res_ga);
      f_gb   = sat_gen(res_gb);
      f_swap = (res_gb < res_ga);
      if (hi == '0) begin
        f_rel = REL_SAME;
      end else if (lo == '0) begin
        f_rel = REL_DIRECT;
        f_rem = sat_gen(hi);
      end else if (lo == hi) begin
        f_rel = REL_EQUAL;
        f_deg = sat_gen(lo - 1'b1);
      end else begin
        f_rel = REL_REMOVED;
        f_deg = sat_gen(lo - 1'b1);
        f_rem = sat_gen(hi - lo);
      end
    end
  end

  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ancestor      <= f_anc;
      out_gen_a         <= f_ga;
      out_gen_b         <= f_gb;
      out_relation      <= f_rel;
      out_swapped       <= f_swap;
      out_cousin_degree <= f_deg;
      out_removal       <= f_rem;
      out_no_common     <= !res_met;
    end
  end

`ifndef SYNTHESIS
  a_stamp_owner_unique: assert property (@(posedge clk) disable iff (rst)
    (valid_a & valid_b) == '0)
    else $error("node stamped by both climbs");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a waiting result");

  a_query_init: assert property (@(posedge clk) disable iff (rst)
    cmd.q_start |=> step == STEP_W'(1) && valid_a == '0 && valid_b == '0)
    else $error("query start did not clear climb state");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step_eval |-> step != '0 && step <= STEP_LAST)
    else $error("step count out of range");
`endif

endmodule

>>> rtl/ancestor_generation_relation.sv
// Load item: accepted in the idle state, writes the parent table, gives no result.
// Query: accepted in the idle state, then each climb step reads the parent
// table (S_READ), then compares and stamps (S_EVAL), at most 130 steps, then
// the result goes to the output register once it is free. One query is worked on at a time.
// Reset (synchronous, active high) clears control state and root to 0; the
// parent table holds no reset value until loaded.
module ancestor_generation_relation
  import agr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_data,
  agr_in_if.sink            in_ch,
  agr_out_if.source         out_ch
);

  agr_cmd_t  cmd;
  agr_stat_t st;

  agr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .st       (st)
  );

  agr_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_node_a         (in_ch.node_a),
    .in_node_b         (in_ch.node_b),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_ancestor      (out_ch.ancestor),
    .out_gen_a         (out_ch.gen_a),
    .out_gen_b         (out_ch.gen_b),
    .out_relation      (out_ch.relation),
    .out_swapped       (out_ch.swapped),
    .out_cousin_degree (out_ch.cousin_degree),
    .out_removal       (out_ch.removal),
    .out_no_common     (out_ch.no_common)
  );

endmodule
